// ===== rtl/core/tmep_pkg.sv =====
// ----------------------------------------------------------------------------
// tmep_pkg
// shared types, constants and helpers of the table-map event parser
// ----------------------------------------------------------------------------
package tmep_pkg;

    localparam int HEADER_LEN       = 19;
    localparam int TABLE_ID_LEN     = 6;
    localparam int MAX_COLUMN_COUNT = 4096;
    localparam int IDX_W            = $clog2(MAX_COLUMN_COUNT);
    localparam int COL_W            = IDX_W + 1;
    localparam int STORE_DEPTH      = MAX_COLUMN_COUNT;

    localparam logic [2:0] K_TABLE_ID = 3'd0;
    localparam logic [2:0] K_DB_BYTE  = 3'd1;
    localparam logic [2:0] K_TBL_BYTE = 3'd2;
    localparam logic [2:0] K_COL_TYPE = 3'd3;
    localparam logic [2:0] K_COL_META = 3'd4;
    localparam logic [2:0] K_NULL_MAP = 3'd5;
    localparam logic [2:0] K_END      = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNCATED = 2'd1;
    localparam logic [1:0] ST_TOO_MANY  = 2'd2;

    typedef enum logic [3:0] {
        PH_HEADER, PH_TABLEID, PH_FLAGS, PH_DBLEN, PH_DBNAME, PH_DBNUL,
        PH_TBLLEN, PH_TBLNAME, PH_TBLNUL, PH_COLCNT, PH_TYPES, PH_METALEN,
        PH_META, PH_BITMAP, PH_DISCARD
    } phase_t;

    typedef enum logic [1:0] {
        C_IDLE, C_DECIDE, C_LOOK, C_OUT
    } ctl_state_t;

    typedef struct packed {
        logic capture;
        logic step;
        logic found;
        logic rd_cur;
        logic skip;
        logic pop;
    } dp_cmd_t;

    typedef struct packed {
        logic need_walk;
        logic skip;
        logic skip_end;
        logic res_valid;
        logic res_last;
    } dp_stat_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [IDX_W-1:0] idx;
        logic [47:0]      val;
        logic [1:0]       st;
        logic             bc;
    } rec_t;

    function automatic logic [1:0] meta_size(input logic [7:0] t);
        logic [1:0] sz;
        case (t) inside
            8'd15, 8'd253, 8'd254, 8'd246, 8'd16, 8'd247, 8'd248:  sz = 2'd2;
            8'd249, 8'd250, 8'd251, 8'd252, 8'd4, 8'd5,
            8'd17, 8'd18, 8'd19:                                   sz = 2'd1;
            default:                                               sz = 2'd0;
        endcase
        return sz;
    endfunction

endpackage

// ===== rtl/core/tmep_if.sv =====
// ----------------------------------------------------------------------------
// tmep_if
// valid/ready channels for event bytes and parsed records
// ----------------------------------------------------------------------------
interface tmep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] event_byte;
    logic       end_of_event;

    modport source (output valid, event_byte, end_of_event, input ready);
    modport sink   (input valid, event_byte, end_of_event, output ready);
endinterface

interface tmep_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  record_kind;
    logic [11:0] column_index;
    logic [47:0] record_value;
    logic [1:0]  parse_status;
    logic        bitmap_complete;
    logic        last_of_run;

    modport source (output valid, record_kind, column_index, record_value, parse_status,
                    bitmap_complete, last_of_run, input ready);
    modport sink   (input valid, record_kind, column_index, record_value, parse_status,
                    bitmap_complete, last_of_run, output ready);
endinterface

// ===== rtl/core/tmep_ram.sv =====
// ----------------------------------------------------------------------------
// tmep_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tmep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/core/tmep_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmep_ctrl
// sequencer: accept a byte, walk the type store if needed, drain records
// ----------------------------------------------------------------------------
module tmep_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output tmep_pkg::dp_cmd_t cmd,
    input  tmep_pkg::dp_stat_t stat
);
    import tmep_pkg::*;

    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = C_DECIDE;
                end
            end
            C_DECIDE:
            begin
                state_next = stat.need_walk ? C_LOOK : C_OUT;
            end
            C_LOOK:
            begin
                if (!stat.skip)
                begin
                    state_next = C_OUT;
                end
                else if (stat.skip_end)
                begin
                    state_next = C_DECIDE;
                end
            end
            C_OUT:
            begin
                if (!stat.res_valid || (out_ready && stat.res_last))
                begin
                    state_next = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            C_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            C_DECIDE:
            begin
                cmd.rd_cur = stat.need_walk;
                cmd.step   = !stat.need_walk;
            end
            C_LOOK:
            begin
                cmd.skip  = stat.skip;
                cmd.step  = !stat.skip;
                cmd.found = !stat.skip;
            end
            C_OUT:
            begin
                out_valid = stat.res_valid;
                cmd.pop   = stat.res_valid && out_ready;
            end
            default: ;
        endcase
    end
endmodule

// ===== rtl/core/tmep_dpath.sv =====
// ----------------------------------------------------------------------------
// tmep_dpath
// parse state, column type store and record buffer
// ----------------------------------------------------------------------------
module tmep_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         event_byte,
    input  logic               end_of_event,
    input  tmep_pkg::dp_cmd_t  cmd,
    output tmep_pkg::dp_stat_t stat,
    output tmep_pkg::rec_t     rec,
    output logic               rec_last
);
    import tmep_pkg::*;

    logic [7:0]       byte_reg;
    logic             last_reg;
    phase_t           phase_reg, phase_next;
    logic [4:0]       fbc_reg, fbc_next;
    logic [47:0]      tid_reg, tid_next;
    logic [7:0]       name_left_reg, name_left_next;
    logic [63:0]      pk_acc_reg, pk_acc_next;
    logic [3:0]       pk_left_reg, pk_left_next;
    logic [COL_W-1:0] total_reg, total_next;
    logic [COL_W-1:0] cursor_reg, cursor_next;
    logic [31:0]      meta_left_reg, meta_left_next;
    logic [7:0]       meta_low_reg, meta_low_next;
    logic [9:0]       bm_seen_reg, bm_seen_next;
    logic [1:0]       err_reg, err_next;
    rec_t             res_reg [2];
    rec_t             res_next [2];
    logic [1:0]       res_n_reg, res_n_next;
    logic [1:0]       rd_ptr_reg;

    logic [7:0]       ram_rdata;
    logic             ram_we;
    logic [COL_W-1:0] cursor_inc;
    logic [1:0]       cur_size;
    logic [9:0]       bm_bytes;

    assign cursor_inc = cursor_reg + 1'b1;
    assign cur_size   = meta_size(ram_rdata);
    assign bm_bytes   = 10'((total_reg + COL_W'(7)) >> 3);
    assign ram_we     = cmd.step && (phase_reg == PH_TYPES);

    tmep_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_type_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cursor_reg[IDX_W-1:0]),
        .wdata (byte_reg),
        .re    (cmd.rd_cur || cmd.skip),
        .raddr (cmd.skip ? cursor_inc[IDX_W-1:0] : cursor_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        stat.need_walk = (phase_reg == PH_META) && (fbc_reg == 5'd0) && (cursor_reg < total_reg);
        stat.skip      = (cur_size == 2'd0) || (32'(cur_size) > meta_left_reg);
        stat.skip_end  = cursor_inc >= total_reg;
        stat.res_valid = rd_ptr_reg != res_n_reg;
        stat.res_last  = (rd_ptr_reg + 2'd1) == res_n_reg;
        rec            = res_reg[rd_ptr_reg[0]];
        rec_last       = stat.res_last;
    end

    // one parse step on the captured byte
    always_comb
    begin
        logic       pk_done;
        logic [1:0] n;
        rec_t       r;
        logic [1:0] st;
        logic       bc;

        pk_done        = 1'b0;
        n              = 2'd0;
        r              = '0;
        st             = ST_OK;
        bc             = 1'b0;
        phase_next     = phase_reg;
        fbc_next       = fbc_reg;
        tid_next       = tid_reg;
        name_left_next = name_left_reg;
        pk_acc_next    = pk_acc_reg;
        pk_left_next   = pk_left_reg;
        total_next     = total_reg;
        cursor_next    = cursor_reg;
        meta_left_next = meta_left_reg;
        meta_low_next  = meta_low_reg;
        bm_seen_next   = bm_seen_reg;
        err_next       = err_reg;
        res_next[0]    = '0;
        res_next[1]    = '0;

        // length-encoded integer feed, shared by count and metadata length
        if (phase_reg == PH_COLCNT || phase_reg == PH_METALEN)
        begin
            if (fbc_reg == 5'd0)
            begin
                fbc_next    = 5'd1;
                pk_acc_next = 64'(byte_reg);
                if (byte_reg < 8'd251)
                begin
                    pk_done = 1'b1;
                end
                else if (byte_reg == 8'd251)
                begin
                    pk_acc_next = '1;
                    pk_done     = 1'b1;
                end
                else
                begin
                    pk_acc_next  = '0;
                    pk_left_next = (byte_reg == 8'd252) ? 4'd2 :
                                   (byte_reg == 8'd253) ? 4'd3 : 4'd8;
                end
            end
            else
            begin
                pk_acc_next  = pk_acc_reg | (64'(byte_reg) << {(fbc_reg[2:0] - 3'd1), 3'b000});
                fbc_next     = fbc_reg + 5'd1;
                pk_left_next = pk_left_reg - 4'd1;
                pk_done      = pk_left_next == 4'd0;
            end
        end

        unique case (phase_reg)
            PH_HEADER:
            begin
                fbc_next = fbc_reg + 5'd1;
                if (fbc_next >= 5'(HEADER_LEN))
                begin
                    phase_next = PH_TABLEID;
                    fbc_next   = '0;
                end
            end
            PH_TABLEID:
            begin
                tid_next = tid_reg | (48'(byte_reg) << {fbc_reg[2:0], 3'b000});
                fbc_next = fbc_reg + 5'd1;
                if (fbc_next >= 5'(TABLE_ID_LEN))
                begin
                    r.kind     = K_TABLE_ID;
                    r.val      = tid_next;
                    res_next[0] = r;
                    n          = 2'd1;
                    phase_next = PH_FLAGS;
                    fbc_next   = '0;
                end
            end
            PH_FLAGS:
            begin
                fbc_next = fbc_reg + 5'd1;
                if (fbc_next >= 5'd2)
                begin
                    phase_next = PH_DBLEN;
                    fbc_next   = '0;
                end
            end
            PH_DBLEN:
            begin
                name_left_next = byte_reg;
                phase_next     = (byte_reg != 8'd0) ? PH_DBNAME : PH_DBNUL;
            end
            PH_TBLLEN:
            begin
                name_left_next = byte_reg;
                phase_next     = (byte_reg != 8'd0) ? PH_TBLNAME : PH_TBLNUL;
            end
            PH_DBNAME, PH_TBLNAME:
            begin
                r.kind      = (phase_reg == PH_DBNAME) ? K_DB_BYTE : K_TBL_BYTE;
                r.val       = 48'(byte_reg);
                res_next[0] = r;
                n           = 2'd1;
                name_left_next = name_left_reg - 8'd1;
                if (name_left_next == 8'd0)
                begin
                    phase_next = (phase_reg == PH_DBNAME) ? PH_DBNUL : PH_TBLNUL;
                end
            end
            PH_DBNUL:
            begin
                phase_next = PH_TBLLEN;
            end
            PH_TBLNUL:
            begin
                phase_next = PH_COLCNT;
                fbc_next   = '0;
            end
            PH_COLCNT:
            begin
                if (pk_done)
                begin
                    fbc_next = '0;
                    if (pk_acc_next > 64'(MAX_COLUMN_COUNT))
                    begin
                        err_next   = ST_TOO_MANY;
                        phase_next = PH_DISCARD;
                    end
                    else
                    begin
                        total_next  = pk_acc_next[COL_W-1:0];
                        cursor_next = '0;
                        phase_next  = (pk_acc_next != 64'd0) ? PH_TYPES : PH_METALEN;
                    end
                end
            end
            PH_TYPES:
            begin
                r.kind      = K_COL_TYPE;
                r.idx       = cursor_reg[IDX_W-1:0];
                r.val       = 48'(byte_reg);
                res_next[0] = r;
                n           = 2'd1;
                cursor_next = cursor_inc;
                if (cursor_inc >= total_reg)
                begin
                    cursor_next = '0;
                    phase_next  = PH_METALEN;
                    fbc_next    = '0;
                end
            end
            PH_METALEN:
            begin
                if (pk_done)
                begin
                    meta_left_next = (pk_acc_next[63:32] != 32'd0) ? '1 : pk_acc_next[31:0];
                    cursor_next    = '0;
                    fbc_next       = '0;
                    phase_next     = (meta_left_next != 32'd0) ? PH_META : PH_BITMAP;
                end
            end
            PH_META:
            begin
                if (fbc_reg == 5'd1)
                begin
                    r.kind      = K_COL_META;
                    r.idx       = cursor_reg[IDX_W-1:0];
                    r.val       = {32'd0, byte_reg, meta_low_reg};
                    res_next[0] = r;
                    n           = 2'd1;
                    cursor_next = cursor_inc;
                    fbc_next    = '0;
                end
                else if (cmd.found)
                begin
                    if (cur_size == 2'd1)
                    begin
                        r.kind      = K_COL_META;
                        r.idx       = cursor_reg[IDX_W-1:0];
                        r.val       = 48'(byte_reg);
                        res_next[0] = r;
                        n           = 2'd1;
                        cursor_next = cursor_inc;
                    end
                    else
                    begin
                        meta_low_next = byte_reg;
                        fbc_next      = 5'd1;
                    end
                end
                meta_left_next = meta_left_reg - 32'd1;
                if (meta_left_next == 32'd0)
                begin
                    phase_next = PH_BITMAP;
                    fbc_next   = '0;
                end
            end
            PH_BITMAP:
            begin
                if (bm_seen_reg < bm_bytes)
                begin
                    r.kind       = K_NULL_MAP;
                    r.idx        = IDX_W'({bm_seen_reg, 3'b000});
                    r.val        = 48'(byte_reg);
                    res_next[0]  = r;
                    n            = 2'd1;
                    bm_seen_next = bm_seen_reg + 10'd1;
                end
            end
            default: ;
        endcase

        if (last_reg)
        begin
            r      = '0;
            r.kind = K_END;
            r.val  = 48'(total_next);
            if (err_next != 2'd0)
            begin
                st    = ST_TOO_MANY;
                r.val = '0;
            end
            else if (phase_next == PH_BITMAP ||
                     (phase_next == PH_METALEN && fbc_next == 5'd0))
            begin
                st = ST_OK;
                bc = bm_seen_next == bm_bytes;
            end
            else
            begin
                st = ST_TRUNCATED;
            end
            r.st = st;
            r.bc = bc;
            if (n == 2'd0)
            begin
                res_next[0] = r;
            end
            else
            begin
                res_next[1] = r;
            end
            n              = n + 2'd1;
            phase_next     = PH_HEADER;
            fbc_next       = '0;
            tid_next       = '0;
            name_left_next = '0;
            pk_acc_next    = '0;
            pk_left_next   = '0;
            total_next     = '0;
            cursor_next    = '0;
            meta_left_next = '0;
            meta_low_next  = '0;
            bm_seen_next   = '0;
            err_next       = '0;
        end
        res_n_next = n;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            byte_reg <= event_byte;
            last_reg <= end_of_event;
        end
        if (cmd.step)
        begin
            res_reg[0] <= res_next[0];
            res_reg[1] <= res_next[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            fbc_reg       <= '0;
            tid_reg       <= '0;
            name_left_reg <= '0;
            pk_acc_reg    <= '0;
            pk_left_reg   <= '0;
            total_reg     <= '0;
            cursor_reg    <= '0;
            meta_left_reg <= '0;
            meta_low_reg  <= '0;
            bm_seen_reg   <= '0;
            err_reg       <= '0;
            res_n_reg     <= '0;
            rd_ptr_reg    <= '0;
        end
        else if (cmd.step)
        begin
            phase_reg     <= phase_next;
            fbc_reg       <= fbc_next;
            tid_reg       <= tid_next;
            name_left_reg <= name_left_next;
            pk_acc_reg    <= pk_acc_next;
            pk_left_reg   <= pk_left_next;
            total_reg     <= total_next;
            cursor_reg    <= cursor_next;
            meta_left_reg <= meta_left_next;
            meta_low_reg  <= meta_low_next;
            bm_seen_reg   <= bm_seen_next;
            err_reg       <= err_next;
            res_n_reg     <= res_n_next;
            rd_ptr_reg    <= '0;
        end
        else
        begin
            if (cmd.skip)
            begin
                cursor_reg <= cursor_inc;
            end
            if (cmd.pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
        end
    end
endmodule

// ===== rtl/core/table_map_event_parser_core.sv =====
// ----------------------------------------------------------------------------
// table_map_event_parser_core
// streaming parser of a table-map event, one byte per transfer
// ----------------------------------------------------------------------------
// one byte at a time: accept, a parse step, then 0 to 2 records drained one
// per cycle while the record sink is ready; the next byte waits for the last.
// a metadata byte that walks the type store reads it once per column looked
// at, and goes back to decide when every remaining column is skipped.
// asynchronous active-low reset returns to the header phase; the type store
// is not cleared and needs no clearing pass.
module table_map_event_parser_core (
    input logic        clk,
    input logic        rst_n,
    tmep_in_if.sink    event_ch,
    tmep_out_if.source record_ch
);
    import tmep_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    rec_t     rec;
    logic     rec_last;

    tmep_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (event_ch.valid),
        .in_ready  (event_ch.ready),
        .out_valid (record_ch.valid),
        .out_ready (record_ch.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    tmep_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .event_byte   (event_ch.event_byte),
        .end_of_event (event_ch.end_of_event),
        .cmd          (cmd),
        .stat         (stat),
        .rec          (rec),
        .rec_last     (rec_last)
    );

    assign record_ch.record_kind     = rec.kind;
    assign record_ch.column_index    = rec.idx;
    assign record_ch.record_value    = rec.val;
    assign record_ch.parse_status    = rec.st;
    assign record_ch.bitmap_complete = rec.bc;
    assign record_ch.last_of_run     = rec_last;
endmodule

// ===== sim/table_map_event_parser_core_tb.sv =====
// ----------------------------------------------------------------------------
// table_map_event_parser_core_tb
// self-checking bench: streams table-map events byte by byte, predicts every
// record in a behavioral model and compares each record transfer in order
// ----------------------------------------------------------------------------
module table_map_event_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tmep_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       eoe;
        logic       hold;
    } byte_item_t;

    typedef struct {
        rec_t r;
        logic last;
    } exp_rec_t;

    logic clk;
    logic rst_n;
    bit   failed;
    bit   quiet;

    tmep_in_if  ev_if();
    tmep_out_if rec_if();

    table_map_event_parser_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .event_ch  (ev_if),
        .record_ch (rec_if)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    byte_item_t pending_bytes[$];
    exp_rec_t   expected_recs[$];
    logic [7:0] ev[$];

    // ------------------------------------------------------------------
    // behavioral parser
    // ------------------------------------------------------------------
    phase_t      ph;
    int unsigned fcnt;
    logic [47:0] tid;
    int unsigned name_left;
    logic [63:0] lenenc_val;
    int unsigned lenenc_left;
    int unsigned ncols;
    int unsigned cur;
    logic [7:0]  type_mem [STORE_DEPTH];
    logic [31:0] meta_left;
    logic [7:0]  meta_low;
    int unsigned bm_seen;
    logic [1:0]  err;

    function automatic int unsigned meta_bytes_of(input logic [7:0] t);
        if (t == 15 || t == 16 || t == 246 || t == 247 || t == 248 || t == 253 || t == 254)
            return 2;
        if (t == 4 || t == 5 || (t >= 17 && t <= 19) || (t >= 249 && t <= 252))
            return 1;
        return 0;
    endfunction

    function void parser_clear();
        ph = PH_HEADER;
        fcnt = 0;
        tid = '0;
        name_left = 0;
        lenenc_val = '0;
        lenenc_left = 0;
        ncols = 0;
        cur = 0;
        meta_left = '0;
        meta_low = '0;
        bm_seen = 0;
        err = ST_OK;
    endfunction

    function void ev_put(input logic [7:0] b);
        ev.insert(ev.size(), b);
    endfunction

    function bit lenenc_take(input logic [7:0] b);
        if (fcnt == 0)
        begin
            fcnt = 1;
            lenenc_val = '0;
            if (b < 251)
            begin
                lenenc_val = b;
                return 1'b1;
            end
            if (b == 251)
            begin
                lenenc_val = '1;
                return 1'b1;
            end
            lenenc_left = (b == 252) ? 2 : (b == 253) ? 3 : 8;
            return 1'b0;
        end
        lenenc_val |= 64'(b) << (8 * ((fcnt - 1) & 7));
        fcnt++;
        lenenc_left--;
        return lenenc_left == 0;
    endfunction

    function void add_rec(input logic [2:0] k, input int unsigned idx, input logic [47:0] v,
                          input logic [1:0] st, input logic bc);
        exp_rec_t e;
        e.r.kind = k;
        e.r.idx  = idx[IDX_W-1:0];
        e.r.val  = v;
        e.r.st   = st;
        e.r.bc   = bc;
        e.last   = 1'b0;
        expected_recs.insert(expected_recs.size(), e);
    endfunction

    function void parse_byte(input logic [7:0] b, input logic eoe);
        int unsigned recs_prior;
        int unsigned sz;
        logic [1:0]  st;
        logic        bc;
        recs_prior = expected_recs.size();
        case (ph)
            PH_HEADER:
            begin
                fcnt++;
                if (fcnt >= HEADER_LEN)
                begin
                    ph = PH_TABLEID;
                    fcnt = 0;
                end
            end
            PH_TABLEID:
            begin
                tid |= 48'(b) << (8 * fcnt);
                fcnt++;
                if (fcnt >= TABLE_ID_LEN)
                begin
                    add_rec(K_TABLE_ID, 0, tid, ST_OK, 1'b0);
                    ph = PH_FLAGS;
                    fcnt = 0;
                end
            end
            PH_FLAGS:
            begin
                fcnt++;
                if (fcnt >= 2)
                begin
                    ph = PH_DBLEN;
                    fcnt = 0;
                end
            end
            PH_DBLEN:
            begin
                name_left = b;
                ph = (b != 0) ? PH_DBNAME : PH_DBNUL;
            end
            PH_TBLLEN:
            begin
                name_left = b;
                ph = (b != 0) ? PH_TBLNAME : PH_TBLNUL;
            end
            PH_DBNAME, PH_TBLNAME:
            begin
                add_rec((ph == PH_DBNAME) ? K_DB_BYTE : K_TBL_BYTE, 0, 48'(b), ST_OK, 1'b0);
                name_left--;
                if (name_left == 0)
                    ph = phase_t'(ph + 1);
            end
            PH_DBNUL: ph = PH_TBLLEN;
            PH_TBLNUL:
            begin
                ph = PH_COLCNT;
                fcnt = 0;
            end
            PH_COLCNT:
            begin
                if (lenenc_take(b))
                begin
                    fcnt = 0;
                    if (lenenc_val > MAX_COLUMN_COUNT)
                    begin
                        err = ST_TOO_MANY;
                        ph = PH_DISCARD;
                    end
                    else
                    begin
                        ncols = int'(lenenc_val);
                        cur = 0;
                        ph = (ncols != 0) ? PH_TYPES : PH_METALEN;
                    end
                end
            end
            PH_TYPES:
            begin
                type_mem[cur % STORE_DEPTH] = b;
                add_rec(K_COL_TYPE, cur, 48'(b), ST_OK, 1'b0);
                cur++;
                if (cur >= ncols)
                begin
                    cur = 0;
                    ph = PH_METALEN;
                    fcnt = 0;
                end
            end
            PH_METALEN:
            begin
                if (lenenc_take(b))
                begin
                    meta_left = (lenenc_val > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : lenenc_val[31:0];
                    cur = 0;
                    fcnt = 0;
                    ph = (meta_left != 0) ? PH_META : PH_BITMAP;
                end
            end
            PH_META:
            begin
                if (fcnt == 1)
                begin
                    add_rec(K_COL_META, cur, 48'({b, meta_low}), ST_OK, 1'b0);
                    cur++;
                    fcnt = 0;
                end
                else
                begin
                    sz = 0;
                    // skip columns without metadata or with too few bytes left
                    while (cur < ncols)
                    begin
                        sz = meta_bytes_of(type_mem[cur % STORE_DEPTH]);
                        if (sz == 0 || sz > meta_left)
                            cur++;
                        else
                            break;
                    end
                    if (cur < ncols)
                    begin
                        if (sz == 1)
                        begin
                            add_rec(K_COL_META, cur, 48'(b), ST_OK, 1'b0);
                            cur++;
                        end
                        else
                        begin
                            meta_low = b;
                            fcnt = 1;
                        end
                    end
                end
                meta_left--;
                if (meta_left == 0)
                begin
                    ph = PH_BITMAP;
                    fcnt = 0;
                end
            end
            PH_BITMAP:
            begin
                if (bm_seen < (ncols + 7) / 8)
                begin
                    add_rec(K_NULL_MAP, bm_seen * 8, 48'(b), ST_OK, 1'b0);
                    bm_seen++;
                end
            end
            default: ;
        endcase
        if (eoe)
        begin
            bc = 1'b0;
            if (err != ST_OK)
            begin
                st = ST_TOO_MANY;
                add_rec(K_END, 0, '0, st, bc);
            end
            else
            begin
                if (ph == PH_BITMAP || (ph == PH_METALEN && fcnt == 0))
                begin
                    st = ST_OK;
                    bc = (bm_seen == (ncols + 7) / 8);
                end
                else
                begin
                    st = ST_TRUNCATED;
                end
                add_rec(K_END, 0, 48'(ncols), st, bc);
            end
            parser_clear();
        end
        if (expected_recs.size() > recs_prior)
            expected_recs[expected_recs.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // event building
    // ------------------------------------------------------------------
    function void put_lenenc(input longint unsigned v, input int form);
        int n;
        if (form == 0 && v < 251)
        begin
            ev_put(v[7:0]);
            return;
        end
        if (form <= 1 && v < 65536)
        begin
            ev_put(8'd252);
            n = 2;
        end
        else if (form <= 2 && v < (1 << 24))
        begin
            ev_put(8'd253);
            n = 3;
        end
        else
        begin
            ev_put(($urandom_range(0, 1) != 0) ? 8'd254 : 8'd255);
            n = 8;
        end
        for (int i = 0; i < n; i++)
            ev_put(8'(v >> (8 * i)));
    endfunction

    function logic [7:0] pick_type();
        logic [7:0] meta_types[16] = '{15, 16, 246, 247, 248, 253, 254,
                                       4, 5, 17, 18, 19, 249, 250, 251, 252};
        if ($urandom_range(0, 2) == 0)
            return 8'($urandom_range(0, 255));
        return meta_types[$urandom_range(0, 15)];
    endfunction

    // builds an event into ev; meta_adj shifts the metadata length around the need
    function void build_event(input int n_cols, input int form, input int meta_adj,
                              input int n_extra, input int db_len);
        int need;
        int mlen;
        int tlen;
        logic [7:0] t;
        ev.delete();
        for (int i = 0; i < HEADER_LEN + TABLE_ID_LEN + 2; i++)
            ev_put(8'($urandom_range(0, 255)));
        ev_put(8'(db_len));
        for (int i = 0; i < db_len; i++)
            ev_put(8'($urandom_range(0, 255)));
        ev_put(8'd0);
        tlen = $urandom_range(0, 6);
        ev_put(8'(tlen));
        for (int i = 0; i < tlen; i++)
            ev_put(8'($urandom_range(0, 255)));
        ev_put(8'd0);
        put_lenenc(n_cols, form);
        if (n_cols > MAX_COLUMN_COUNT)
        begin
            for (int i = 0; i < n_extra; i++)
                ev_put(8'($urandom_range(0, 255)));
            return;
        end
        need = 0;
        for (int i = 0; i < n_cols; i++)
        begin
            t = pick_type();
            ev_put(t);
            need += meta_bytes_of(t);
        end
        mlen = need + meta_adj;
        if (mlen < 0)
            mlen = 0;
        put_lenenc(mlen, $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
        for (int i = 0; i < mlen; i++)
            ev_put(8'($urandom_range(0, 255)));
        for (int i = 0; i < (n_cols + 7) / 8 + n_extra; i++)
            ev_put(8'($urandom_range(0, 255)));
    endfunction

    // queues the first len bytes of ev, the last one flagged as end of event
    function void queue_event(input int len, input bit hold);
        byte_item_t it;
        if (len <= 0 || len > ev.size())
            len = ev.size();
        for (int i = 0; i < len; i++)
        begin
            it.data = ev[i];
            it.eoe  = (i == len - 1);
            it.hold = hold && (i == 0);
            pending_bytes.insert(pending_bytes.size(), it);
        end
    endfunction

    // ------------------------------------------------------------------
    // byte driver
    // ------------------------------------------------------------------
    int unsigned src_gap;

    always @(posedge clk or negedge rst_n)
    begin
        logic       nv;
        logic [7:0] nb;
        logic       ne;
        if (!rst_n)
        begin
            ev_if.valid        <= 1'b0;
            ev_if.event_byte   <= '0;
            ev_if.end_of_event <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            nv = ev_if.valid;
            nb = ev_if.event_byte;
            ne = ev_if.end_of_event;
            if (ev_if.valid && ev_if.ready)
            begin
                parse_byte(ev_if.event_byte, ev_if.end_of_event);
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                end
                else if (pending_bytes.size() > 0 &&
                         (!pending_bytes[0].hold || expected_recs.size() == 0))
                begin
                    nv = 1'b1;
                    nb = pending_bytes[0].data;
                    ne = pending_bytes[0].eoe;
                    pending_bytes.pop_front();
                    if (!quiet && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 9);
                end
            end
            ev_if.valid        <= nv;
            ev_if.event_byte   <= nb;
            ev_if.end_of_event <= ne;
        end
    end

    // ------------------------------------------------------------------
    // record monitor
    // ------------------------------------------------------------------
    int unsigned snk_gap;

    always @(posedge clk or negedge rst_n)
    begin
        exp_rec_t e;
        if (!rst_n)
        begin
            rec_if.ready <= 1'b0;
            snk_gap = 0;
        end
        else
        begin
            if (rec_if.valid && rec_if.ready)
            begin
                if (expected_recs.size() == 0)
                begin
                    $display("%0t: unexpected record kind=%0d idx=%0d val=%0h", $realtime,
                             rec_if.record_kind, rec_if.column_index, rec_if.record_value);
                    failed = 1'b1;
                end
                else
                begin
                    e = expected_recs.pop_front();
                    if (rec_if.record_kind !== e.r.kind || rec_if.column_index !== e.r.idx ||
                        rec_if.record_value !== e.r.val || rec_if.parse_status !== e.r.st ||
                        rec_if.bitmap_complete !== e.r.bc || rec_if.last_of_run !== e.last)
                    begin
                        $display("%0t: expected kind=%0d idx=%0d val=%0h st=%0d bc=%0b last=%0b",
                                 $realtime, e.r.kind, e.r.idx, e.r.val, e.r.st, e.r.bc, e.last);
                        $display("%0t: actual   kind=%0d idx=%0d val=%0h st=%0d bc=%0b last=%0b",
                                 $realtime, rec_if.record_kind, rec_if.column_index,
                                 rec_if.record_value, rec_if.parse_status,
                                 rec_if.bitmap_complete, rec_if.last_of_run);
                        failed = 1'b1;
                    end
                end
            end
            if (snk_gap > 0)
            begin
                snk_gap--;
                rec_if.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                snk_gap = $urandom_range(0, 8);
                rec_if.ready <= 1'b0;
            end
            else
            begin
                rec_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int total;
        int cols;
        failed = 1'b0;
        quiet  = 1'b0;
        parser_clear();
        rst_n = 1'b1;
        #1;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed events
        build_event(3, 0, 0, 0, 2);       queue_event(0, 0);
        build_event(0, 0, 0, 0, 0);       queue_event(0, 0);
        // ends right after the type bytes, no metadata
        build_event(5, 1, 0, 0, 1);
        queue_event(HEADER_LEN + 8 + 1 + 1 + 1 + 2 + ev[HEADER_LEN + 8 + 1 + 1 + 1] + 3 + 5, 0);
        build_event(8, 0, -1, 2, 3);      queue_event(0, 0);
        build_event(4, 2, 3, 0, 0);       queue_event(0, 0);
        build_event(4097, 1, 0, 3, 0);    queue_event(0, 0);
        // largest legal column count, cut inside the type bytes
        build_event(MAX_COLUMN_COUNT, 1, 0, 0, 1);
        queue_event(64, 1);
        build_event(6, 3, 0, 1, 255);     queue_event(0, 0);
        // single-byte event, cut inside the header
        build_event(1, 0, 0, 0, 0);       queue_event(1, 0);
        // column count byte meaning all ones
        ev.delete();
        for (int i = 0; i < HEADER_LEN + 8; i++)
            ev_put(8'hFF);
        ev_put(8'd0); ev_put(8'd0); ev_put(8'd0); ev_put(8'd0);
        ev_put(8'd251); ev_put(8'h00);
        queue_event(0, 0);
        // huge metadata length saturates, event cut inside the metadata
        ev.delete();
        for (int i = 0; i < HEADER_LEN + 8; i++)
            ev_put(8'h00);
        ev_put(8'd0); ev_put(8'd0); ev_put(8'd0); ev_put(8'd0);
        ev_put(8'd2); ev_put(8'd15); ev_put(8'd4);
        ev_put(8'd255);
        for (int i = 0; i < 8; i++)
            ev_put(8'hFF);
        for (int i = 0; i < 4; i++)
            ev_put(8'($urandom_range(0, 255)));
        queue_event(0, 1);

        // random events, mostly well formed, some cut anywhere
        total = pending_bytes.size();
        while (total < 950)
        begin
            cols = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 20);
            if ($urandom_range(0, 30) == 0)
                cols = MAX_COLUMN_COUNT + $urandom_range(1, 3);
            build_event(cols, $urandom_range(0, 4) == 0 ? $urandom_range(1, 3) : 0,
                        $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 6)) - 3 : 0,
                        $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0,
                        $urandom_range(0, 8));
            if ($urandom_range(0, 4) == 0)
                queue_event($urandom_range(1, ev.size()), $urandom_range(0, 9) == 0);
            else
                queue_event(0, $urandom_range(0, 9) == 0);
            total = pending_bytes.size();
        end

        wait (pending_bytes.size() < 150);
        quiet = 1'b1;
        wait (pending_bytes.size() == 0 && !ev_if.valid);
        wait (expected_recs.size() == 0);
        repeat (5000) @(posedge clk);
        if (!failed && expected_recs.size() == 0)
            $display("** table_map_event_parser_core: PASSED **");
        else
            $display("** table_map_event_parser_core: FAILED **");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("** table_map_event_parser_core: FAILED **");
        $finish;
    end

endmodule
